[src/stq_pkg.sv]
// Shared types, constants and helpers of the sorted timer queue.
package stq_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);
   localparam int HANDLE_W    = 16;
   localparam int TIME_W      = 48;
   localparam int CFG_W       = 16;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [IDX_W:0]      idx_ext_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [RES_W-1:0]    res_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [CFG_W-1:0]    cfg_type;

   localparam cnt_type     DEPTH_CNT        = cnt_type'(DEPTH);
   localparam idx_ext_type DEPTH_EXT        = idx_ext_type'(DEPTH);
   localparam res_type     MAX_RES          = res_type'(MAX_RESULTS);
   localparam cfg_type     IDLE_DELAY_RESET = cfg_type'(100);

   typedef enum logic [1:0] {
      ACT_SCHEDULE = 2'd0,
      ACT_CANCEL   = 2'd1,
      ACT_DRAIN    = 2'd2,
      ACT_QUERY    = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      KIND_SCHEDULED  = 4'd0,
      KIND_FULL       = 4'd1,
      KIND_CANCELLED  = 4'd2,
      KIND_NOT_FOUND  = 4'd3,
      KIND_CFIFO_FULL = 4'd4,
      KIND_ABORTED    = 4'd5,
      KIND_EXPIRED    = 4'd6,
      KIND_NOTHING    = 4'd7,
      KIND_DELAY      = 4'd8
   } kind_type;

   typedef struct packed {
      logic [1:0] action;
      handle_type timer_handle;
      time_type   expiry_time;
      time_type   now_time;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      handle_type out_handle;
      time_type   delay_ms;
      logic       last;
   } rsp_type;

   typedef struct packed {
      handle_type handle;
      time_type   expiry;
   } slot_type;

   // Ring index arithmetic: (base + offs) mod DEPTH, both operands below DEPTH.
   function automatic idx_type stq_wrap(input idx_type base, input idx_type offs);
      idx_ext_type sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

[src/stq_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module stq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sorted_timer_queue.sv]
// Top level of the sorted timer queue: sequencer, timer store and cancel FIFO.
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one action per
//   transaction: schedule, cancel, drain or query. req_stall is high whenever
//   the sequencer is busy; one action is worked on at a time.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns the results. Every
//   action except drain returns one transaction; a drain returns one per
//   aborted or expired timer (or one "nothing due"), the final one with last = 1.
//   csr channel (csr_valid / csr_ready / csr_data) writes idle_delay; write it
//   only while no action is in flight. csr_ready is always high.
// A query looks only at the head slot, while schedule and cancel walk the
//   store and a drain steps through its results. Each result is registered
//   and valid the cycle after the step that makes it; a drain holds each result
//   back one step to learn whether it is the last. The single read port of the
//   store RAM sets this pace: the sequencer walks the sorted ring one slot per
//   cycle, moving entries up on insert and down on removal. Reset clears the
//   counts and ring pointers, so the store is empty; the RAM contents are left
//   as they are and no clearing pass is needed.
// A stall on rsp holds the output register; the sequencer waits with its
//   next result and keeps req_stall high until the action is finished.
module sorted_timer_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  stq_pkg::cfg_type csr_data
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SCH    = 9'b000000010,
      ST_INS    = 9'b000000100,
      ST_INS0   = 9'b000001000,
      ST_CSRCH  = 9'b000010000,
      ST_CSHIFT = 9'b000100000,
      ST_DABORT = 9'b001000000,
      ST_DEXP   = 9'b010000000,
      ST_QRY    = 9'b100000000
   } state_type;

   // Control state
   state_type             state_ff,       state_in;
   stq_pkg::idx_type      idx_ff,         idx_in;
   stq_pkg::idx_type      head_ff,        head_in;
   stq_pkg::cnt_type      timer_count_ff, timer_count_in;
   stq_pkg::idx_type      cf_head_ff,     cf_head_in;
   stq_pkg::cnt_type      cf_count_ff,    cf_count_in;
   stq_pkg::res_type      res_cnt_ff,     res_cnt_in;
   logic                  pend_valid_ff,  pend_valid_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   stq_pkg::cfg_type      idle_delay_ff,  idle_delay_in;

   // Payload state
   stq_pkg::req_type      item_ff,        item_in;
   stq_pkg::kind_type     pend_kind_ff,   pend_kind_in;
   stq_pkg::handle_type   pend_handle_ff, pend_handle_in;
   stq_pkg::rsp_type      rsp_data_ff,    rsp_data_in;

   // Memory ports
   logic                  slot_wr_en;
   stq_pkg::idx_type      slot_wr_addr;
   stq_pkg::slot_type     slot_wr_data;
   stq_pkg::idx_type      slot_rd_addr;
   stq_pkg::slot_type     slot_rd_data;
   logic                  cf_wr_en;
   stq_pkg::idx_type      cf_wr_addr;
   stq_pkg::handle_type   cf_rd_data;

   // Helpers
   logic                  accept;
   logic                  out_free;
   logic                  rsp_load;
   stq_pkg::rsp_type      rsp_next;
   stq_pkg::cnt_type      cnt_m1;
   logic                  idx_last;
   stq_pkg::slot_type     new_slot;
   logic                  res_room;
   logic                  abort_cand;
   logic                  exp_cand;
   stq_pkg::time_type     delay_left;

   // Sorted timer ring: logical slot k lives at (head + k) mod DEPTH.
   stq_ram #(
      .WIDTH ($bits(stq_pkg::slot_type)),
      .DEPTH (stq_pkg::DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // Cancel FIFO ring: oldest entry at cf_head.
   stq_ram #(
      .WIDTH (stq_pkg::HANDLE_W),
      .DEPTH (stq_pkg::DEPTH)
   ) u_cfifo_ram (
      .clock   (clock),
      .wr_en   (cf_wr_en),
      .wr_addr (cf_wr_addr),
      .wr_data (item_ff.timer_handle),
      .rd_addr (cf_head_in),
      .rd_data (cf_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign cnt_m1     = timer_count_ff - stq_pkg::cnt_type'(1);
   assign idx_last   = (stq_pkg::cnt_type'(idx_ff) == cnt_m1);
   assign new_slot   = '{handle: item_ff.timer_handle, expiry: item_ff.expiry_time};
   assign res_room   = (res_cnt_ff < stq_pkg::MAX_RES);
   assign abort_cand = (cf_count_ff != '0) && res_room;
   assign exp_cand   = (timer_count_ff != '0) && res_room &&
                       (slot_rd_data.expiry <= item_ff.now_time);
   assign delay_left = slot_rd_data.expiry - item_ff.now_time;
   assign cf_wr_addr = stq_pkg::stq_wrap(cf_head_ff, cf_count_ff[stq_pkg::IDX_W-1:0]);

   // Always read the slot that the sequencer looks at in the next cycle.
   assign slot_rd_addr = stq_pkg::stq_wrap(head_in, idx_in);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      timer_count_in = timer_count_ff;
      cf_head_in     = cf_head_ff;
      cf_count_in    = cf_count_ff;
      res_cnt_in     = res_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_handle_in = pend_handle_ff;
      item_in        = item_ff;
      idle_delay_in  = csr_valid ? csr_data : idle_delay_ff;

      slot_wr_en     = 1'b0;
      slot_wr_addr   = head_ff;
      slot_wr_data   = new_slot;
      cf_wr_en       = 1'b0;

      rsp_load            = 1'b0;
      rsp_next.kind       = stq_pkg::KIND_SCHEDULED;
      rsp_next.out_handle = item_ff.timer_handle;
      rsp_next.delay_ms   = '0;
      rsp_next.last       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in       = req_data;
               idx_in        = '0;
               res_cnt_in    = '0;
               pend_valid_in = 1'b0;
               unique case (req_data.action)
                  stq_pkg::ACT_SCHEDULE: state_in = ST_SCH;
                  stq_pkg::ACT_CANCEL:   state_in = ST_CSRCH;
                  stq_pkg::ACT_DRAIN:    state_in = ST_DABORT;
                  stq_pkg::ACT_QUERY:    state_in = ST_QRY;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end

         ST_SCH: begin
            if (timer_count_ff >= stq_pkg::DEPTH_CNT) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_next.kind = stq_pkg::KIND_FULL;
                  state_in      = ST_IDLE;
               end
            end else if (timer_count_ff == '0) begin
               if (out_free) begin
                  slot_wr_en     = 1'b1;
                  timer_count_in = timer_count_ff + stq_pkg::cnt_type'(1);
                  rsp_load       = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               // Walk from the tail toward the head
               idx_in   = cnt_m1[stq_pkg::IDX_W-1:0];
               state_in = ST_INS;
            end
         end

         ST_INS: begin
            if (slot_rd_data.expiry > item_ff.expiry_time) begin
               // Move the later timer up one slot
               slot_wr_en   = 1'b1;
               slot_wr_addr = stq_pkg::stq_wrap(head_ff, idx_ff + stq_pkg::idx_type'(1));
               slot_wr_data = slot_rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_INS0;
               end else begin
                  idx_in = idx_ff - stq_pkg::idx_type'(1);
               end
            end else if (out_free) begin
               slot_wr_en     = 1'b1;
               slot_wr_addr   = stq_pkg::stq_wrap(head_ff, idx_ff + stq_pkg::idx_type'(1));
               timer_count_in = timer_count_ff + stq_pkg::cnt_type'(1);
               rsp_load       = 1'b1;
               idx_in         = '0;
               state_in       = ST_IDLE;
            end
         end

         ST_INS0: begin
            if (out_free) begin
               slot_wr_en     = 1'b1;
               timer_count_in = timer_count_ff + stq_pkg::cnt_type'(1);
               rsp_load       = 1'b1;
               idx_in         = '0;
               state_in       = ST_IDLE;
            end
         end

         ST_CSRCH: begin
            if (timer_count_ff == '0) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_next.kind = stq_pkg::KIND_NOT_FOUND;
                  state_in      = ST_IDLE;
               end
            end else if (slot_rd_data.handle == item_ff.timer_handle) begin
               if (cf_count_ff >= stq_pkg::DEPTH_CNT) begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_next.kind = stq_pkg::KIND_CFIFO_FULL;
                     idx_in        = '0;
                     state_in      = ST_IDLE;
                  end
               end else if (idx_last) begin
                  if (out_free) begin
                     cf_wr_en       = 1'b1;
                     cf_count_in    = cf_count_ff + stq_pkg::cnt_type'(1);
                     timer_count_in = cnt_m1;
                     rsp_load       = 1'b1;
                     rsp_next.kind  = stq_pkg::KIND_CANCELLED;
                     idx_in         = '0;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  cf_wr_en    = 1'b1;
                  cf_count_in = cf_count_ff + stq_pkg::cnt_type'(1);
                  idx_in      = idx_ff + stq_pkg::idx_type'(1);
                  state_in    = ST_CSHIFT;
               end
            end else if (idx_last) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_next.kind = stq_pkg::KIND_NOT_FOUND;
                  idx_in        = '0;
                  state_in      = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + stq_pkg::idx_type'(1);
            end
         end

         ST_CSHIFT: begin
            // Close the gap: copy slot idx down to idx - 1
            if (!idx_last || out_free) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = stq_pkg::stq_wrap(head_ff, idx_ff - stq_pkg::idx_type'(1));
               slot_wr_data = slot_rd_data;
            end
            if (!idx_last) begin
               idx_in = idx_ff + stq_pkg::idx_type'(1);
            end else if (out_free) begin
               timer_count_in = cnt_m1;
               rsp_load       = 1'b1;
               rsp_next.kind  = stq_pkg::KIND_CANCELLED;
               idx_in         = '0;
               state_in       = ST_IDLE;
            end
         end

         ST_DABORT: begin
            // One result is held back until we know whether another follows
            if (abort_cand) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_load            = 1'b1;
                     rsp_next.kind       = pend_kind_ff;
                     rsp_next.out_handle = pend_handle_ff;
                     rsp_next.last       = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_kind_in   = stq_pkg::KIND_ABORTED;
                  pend_handle_in = cf_rd_data;
                  cf_head_in     = stq_pkg::stq_wrap(cf_head_ff, stq_pkg::idx_type'(1));
                  cf_count_in    = cf_count_ff - stq_pkg::cnt_type'(1);
                  res_cnt_in     = res_cnt_ff + stq_pkg::res_type'(1);
               end
            end else begin
               state_in = ST_DEXP;
            end
         end

         ST_DEXP: begin
            if (exp_cand) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_load            = 1'b1;
                     rsp_next.kind       = pend_kind_ff;
                     rsp_next.out_handle = pend_handle_ff;
                     rsp_next.last       = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_kind_in   = stq_pkg::KIND_EXPIRED;
                  pend_handle_in = slot_rd_data.handle;
                  head_in        = stq_pkg::stq_wrap(head_ff, stq_pkg::idx_type'(1));
                  timer_count_in = cnt_m1;
                  res_cnt_in     = res_cnt_ff + stq_pkg::res_type'(1);
               end
            end else if (out_free) begin
               rsp_load = 1'b1;
               if (pend_valid_ff) begin
                  rsp_next.kind       = pend_kind_ff;
                  rsp_next.out_handle = pend_handle_ff;
               end else begin
                  rsp_next.kind       = stq_pkg::KIND_NOTHING;
                  rsp_next.out_handle = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_QRY: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_next.kind       = stq_pkg::KIND_DELAY;
               rsp_next.out_handle = '0;
               if (timer_count_ff == '0 || slot_rd_data.expiry <= item_ff.now_time) begin
                  rsp_next.delay_ms = stq_pkg::time_type'(idle_delay_ff);
               end else begin
                  rsp_next.delay_ms = delay_left;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         head_ff        <= '0;
         timer_count_ff <= '0;
         cf_head_ff     <= '0;
         cf_count_ff    <= '0;
         res_cnt_ff     <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         idle_delay_ff  <= stq_pkg::IDLE_DELAY_RESET;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         head_ff        <= head_in;
         timer_count_ff <= timer_count_in;
         cf_head_ff     <= cf_head_in;
         cf_count_ff    <= cf_count_in;
         res_cnt_ff     <= res_cnt_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         idle_delay_ff  <= idle_delay_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      pend_kind_ff   <= pend_kind_in;
      pend_handle_ff <= pend_handle_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Store and cancel FIFO never exceed their depth
   assert property (@(posedge clock) disable iff (reset)
      timer_count_ff <= stq_pkg::DEPTH_CNT)
      else $error("timer count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      cf_count_ff <= stq_pkg::DEPTH_CNT)
      else $error("cancel FIFO count beyond depth");

   // A drain never leaves a held-back result behind
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending drain result left in idle");

   // Insertion walk only runs on a partly filled store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |->
         (timer_count_ff != '0) && (timer_count_ff < stq_pkg::DEPTH_CNT))
      else $error("insert walk on empty or full store");

endmodule
